FILE: hdl/gic_pkg.sv
// gic_pkg: shared types and constants for the gamepad input conditioner
// no dependencies
package gic_pkg;

  localparam int unsigned CfgIdxW = 2;
  localparam int unsigned CfgDataW = 16;

  typedef enum logic [CfgIdxW-1:0] {
    REG_TRIGGER_THRESHOLD = 2'd0,
    REG_LEFT_DEADZONE     = 2'd1,
    REG_RIGHT_DEADZONE    = 2'd2,
    REG_UNUSED            = 2'd3
  } reg_idx_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_TRIG,
    ST_TRIG_RUN,
    ST_STICK,
    ST_SQRT_RUN,
    ST_DEN,
    ST_NUM_X,
    ST_DIV_X,
    ST_NUM_Y,
    ST_DIV_Y,
    ST_NEXT,
    ST_OUT
  } state_t;

  // controller to datapath
  typedef struct packed {
    logic       load;
    logic       trig_start;
    logic       trig_sel;
    logic       trig_store;
    logic       stick_sel;
    logic       stick_setup;
    logic       sqrt_start;
    logic       den_calc;
    logic       num_x;
    logic       num_y;
    logic       store_x;
    logic       store_y;
  } cmd_t;

  // datapath to controller
  typedef struct packed {
    logic       div_done;
    logic       sqrt_done;
    logic       stick_zero;
  } status_t;

endpackage

FILE: hdl/gic_if.sv
// gic_if: valid/ready channel interfaces for the gamepad input conditioner
// depends on gic_pkg
interface gic_in_if;
  logic               valid;
  logic               ready;
  logic [15:0]        buttons;
  logic [7:0]         left_trigger;
  logic [7:0]         right_trigger;
  logic signed [15:0] left_stick_x;
  logic signed [15:0] left_stick_y;
  logic signed [15:0] right_stick_x;
  logic signed [15:0] right_stick_y;
  modport source (output valid, buttons, left_trigger, right_trigger, left_stick_x,
                  left_stick_y, right_stick_x, right_stick_y, input ready);
  modport sink (input valid, buttons, left_trigger, right_trigger, left_stick_x,
                left_stick_y, right_stick_x, right_stick_y, output ready);
endinterface

interface gic_out_if;
  logic               valid;
  logic               ready;
  logic [23:0]        down_mask;
  logic [23:0]        pressed_mask;
  logic [15:0]        left_trigger_level;
  logic [15:0]        right_trigger_level;
  logic signed [15:0] left_out_x;
  logic signed [15:0] left_out_y;
  logic signed [15:0] right_out_x;
  logic signed [15:0] right_out_y;
  modport source (output valid, down_mask, pressed_mask, left_trigger_level,
                  right_trigger_level, left_out_x, left_out_y, right_out_x,
                  right_out_y, input ready);
  modport sink (input valid, down_mask, pressed_mask, left_trigger_level,
                right_trigger_level, left_out_x, left_out_y, right_out_x,
                right_out_y, output ready);
endinterface

interface gic_cfg_if;
  logic                          valid;
  logic                          ready;
  logic [gic_pkg::CfgIdxW-1:0]   index;
  logic [gic_pkg::CfgDataW-1:0]  data;
  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

FILE: hdl/gamepad_input_conditioner_top.sv
// channel    dir  handshake     payload
// in         in   valid/ready   buttons, triggers, four stick axes
// out        out  valid/ready   masks, trigger levels, stick vectors
// cfg        in   valid/ready   register index, write data
// one poll's duration is set by the single shared bit-serial divider
// (up to six divides) and the sqrt unit
// one poll at a time; in.ready high only when idle, held result waits for out.ready
// synchronous reset restores register defaults and clears the previous down mask
// depends on gic_pkg, gic_if, gic_ctrl, gic_dp
module gamepad_input_conditioner_top #(
  parameter int unsigned STICK_FRAC_BITS = 15
) (
  input logic        clk,
  input logic        rst,
  gic_in_if.sink     in,
  gic_out_if.source  out,
  gic_cfg_if.sink    cfg
);
  gic_pkg::cmd_t    cmd;
  gic_pkg::status_t status;
  logic [7:0]       trigger_threshold;
  logic [14:0]      left_deadzone;
  logic [14:0]      right_deadzone;

  assign cfg.ready = !rst;

  always_ff @(posedge clk) begin
    if (rst) begin
      trigger_threshold <= 8'd30;
      left_deadzone <= 15'd7849;
      right_deadzone <= 15'd8689;
    end else if (cfg.valid) begin
      case (gic_pkg::reg_idx_t'(cfg.index))
        gic_pkg::REG_TRIGGER_THRESHOLD: trigger_threshold <= cfg.data[7:0];
        gic_pkg::REG_LEFT_DEADZONE: left_deadzone <= cfg.data[14:0];
        gic_pkg::REG_RIGHT_DEADZONE: right_deadzone <= cfg.data[14:0];
        default: begin
        end
      endcase
    end
  end

  gic_ctrl u_ctrl (
    .clk(clk), .rst(rst), .in_valid(in.valid), .in_ready(in.ready),
    .out_valid(out.valid), .out_ready(out.ready), .status(status), .cmd(cmd)
  );

  gic_dp #(.STICK_FRAC_BITS(STICK_FRAC_BITS)) u_dp (
    .clk(clk), .rst(rst), .cmd(cmd), .status(status),
    .trigger_threshold(trigger_threshold), .left_deadzone(left_deadzone),
    .right_deadzone(right_deadzone), .buttons(in.buttons),
    .left_trigger(in.left_trigger), .right_trigger(in.right_trigger),
    .left_stick_x(in.left_stick_x), .left_stick_y(in.left_stick_y),
    .right_stick_x(in.right_stick_x), .right_stick_y(in.right_stick_y),
    .down_mask(out.down_mask), .pressed_mask(out.pressed_mask),
    .left_trigger_level(out.left_trigger_level),
    .right_trigger_level(out.right_trigger_level),
    .left_out_x(out.left_out_x), .left_out_y(out.left_out_y),
    .right_out_x(out.right_out_x), .right_out_y(out.right_out_y)
  );
endmodule

FILE: hdl/gic_div.sv
// gic_div: restoring bit-serial unsigned divider, one quotient bit per cycle
// no package dependencies
module gic_div #(
  parameter int unsigned W = 64
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         start,
  input  logic [W-1:0] dividend,
  input  logic [W-1:0] divisor,
  output logic         done,
  output logic [W-1:0] quotient
);
  localparam int unsigned CntW = $clog2(W + 1);

  logic [W-1:0]    rem;
  logic [W-1:0]    dvd;
  logic [W-1:0]    dsr;
  logic [CntW-1:0] cnt;
  logic            busy;
  logic [W:0]      trial;
  logic [W:0]      shifted;

  assign shifted = {rem, dvd[W-1]};
  assign trial = shifted - {1'b0, dsr};
  assign quotient = dvd;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt <= CntW'(W);
      end else if (busy) begin
        cnt <= cnt - 1'b1;
        if (cnt == CntW'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem <= '0;
      dvd <= dividend;
      dsr <= divisor;
    end else if (busy) begin
      if (!trial[W]) begin
        rem <= trial[W-1:0];
        dvd <= {dvd[W-2:0], 1'b1};
      end else begin
        rem <= shifted[W-1:0];
        dvd <= {dvd[W-2:0], 1'b0};
      end
    end
  end
endmodule

FILE: hdl/gic_sqrt.sv
// gic_sqrt: digit-by-digit integer square root, one result bit per cycle
// no package dependencies
module gic_sqrt #(
  parameter int unsigned W = 48
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           start,
  input  logic [W-1:0]   radicand,
  output logic           done,
  output logic [W/2-1:0] root
);
  localparam int unsigned RW = W / 2;
  localparam int unsigned CntW = $clog2(RW + 1);

  logic [W-1:0]    n;
  logic [RW+1:0]   rem;
  logic [RW-1:0]   res;
  logic [CntW-1:0] cnt;
  logic            busy;
  logic [RW+1:0]   shifted;
  logic [RW+1:0]   trial;

  assign shifted = {rem[RW-1:0], n[W-1:W-2]};
  assign trial = shifted - {res, 2'b01};
  assign root = res;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt <= CntW'(RW);
      end else if (busy) begin
        cnt <= cnt - 1'b1;
        if (cnt == CntW'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      n <= radicand;
      rem <= '0;
      res <= '0;
    end else if (busy) begin
      n <= {n[W-3:0], 2'b00};
      if (!trial[RW+1]) begin
        rem <= trial;
        res <= {res[RW-2:0], 1'b1};
      end else begin
        rem <= shifted;
        res <= {res[RW-2:0], 1'b0};
      end
    end
  end
endmodule

FILE: hdl/gic_ctrl.sv
// gic_ctrl: sequencer for triggers, stick sqrt and shared divider
// depends on gic_pkg
module gic_ctrl (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  output logic             in_ready,
  output logic             out_valid,
  input  logic             out_ready,
  input  gic_pkg::status_t status,
  output gic_pkg::cmd_t    cmd
);
  gic_pkg::state_t state;
  gic_pkg::state_t state_next;
  logic            sel;
  logic            sel_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= gic_pkg::ST_IDLE;
      sel <= 1'b0;
    end else begin
      state <= state_next;
      sel <= sel_next;
    end
  end

  always_comb begin
    state_next = state;
    sel_next = sel;
    cmd = '0;
    cmd.trig_sel = sel;
    cmd.stick_sel = sel;
    in_ready = 1'b0;
    out_valid = 1'b0;
    case (state)
      gic_pkg::ST_IDLE: begin
        in_ready = !rst;
        if (in_valid && !rst) begin
          cmd.load = 1'b1;
          sel_next = 1'b0;
          state_next = gic_pkg::ST_TRIG;
        end
      end
      gic_pkg::ST_TRIG: begin
        cmd.trig_start = 1'b1;
        state_next = gic_pkg::ST_TRIG_RUN;
      end
      gic_pkg::ST_TRIG_RUN: begin
        if (status.div_done) begin
          cmd.trig_store = 1'b1;
          if (sel) begin
            sel_next = 1'b0;
            state_next = gic_pkg::ST_STICK;
          end else begin
            sel_next = 1'b1;
            state_next = gic_pkg::ST_TRIG;
          end
        end
      end
      gic_pkg::ST_STICK: begin
        cmd.stick_setup = 1'b1;
        state_next = gic_pkg::ST_SQRT_RUN;
      end
      gic_pkg::ST_SQRT_RUN: begin
        if (status.stick_zero) begin
          cmd.store_x = 1'b1;
          cmd.store_y = 1'b1;
          state_next = gic_pkg::ST_NEXT;
        end else begin
          cmd.sqrt_start = 1'b1;
          state_next = gic_pkg::ST_DEN;
        end
      end
      gic_pkg::ST_DEN: begin
        if (status.sqrt_done) begin
          cmd.den_calc = 1'b1;
          state_next = gic_pkg::ST_NUM_X;
        end
      end
      gic_pkg::ST_NUM_X: begin
        if (status.stick_zero) begin
          cmd.store_x = 1'b1;
          cmd.store_y = 1'b1;
          state_next = gic_pkg::ST_NEXT;
        end else begin
          cmd.num_x = 1'b1;
          state_next = gic_pkg::ST_DIV_X;
        end
      end
      gic_pkg::ST_DIV_X: begin
        if (status.div_done) begin
          cmd.store_x = 1'b1;
          cmd.num_y = 1'b1;
          state_next = gic_pkg::ST_DIV_Y;
        end
      end
      gic_pkg::ST_DIV_Y: begin
        if (status.div_done) begin
          cmd.store_y = 1'b1;
          state_next = gic_pkg::ST_NEXT;
        end
      end
      gic_pkg::ST_NEXT: begin
        if (sel) begin
          state_next = gic_pkg::ST_OUT;
        end else begin
          sel_next = 1'b1;
          state_next = gic_pkg::ST_STICK;
        end
      end
      gic_pkg::ST_OUT: begin
        out_valid = 1'b1;
        if (out_ready) begin
          state_next = gic_pkg::ST_IDLE;
        end
      end
      default: begin
        state_next = gic_pkg::ST_IDLE;
      end
    endcase
  end
endmodule

FILE: hdl/gic_dp.sv
// gic_dp: datapath with masks, trigger scaling and stick normalization
// depends on gic_pkg, gic_div, gic_sqrt
module gic_dp #(
  parameter int unsigned STICK_FRAC_BITS = 15
) (
  input  logic                        clk,
  input  logic                        rst,
  input  gic_pkg::cmd_t               cmd,
  output gic_pkg::status_t            status,
  input  logic [7:0]                  trigger_threshold,
  input  logic [14:0]                 left_deadzone,
  input  logic [14:0]                 right_deadzone,
  input  logic [15:0]                 buttons,
  input  logic [7:0]                  left_trigger,
  input  logic [7:0]                  right_trigger,
  input  logic signed [15:0]          left_stick_x,
  input  logic signed [15:0]          left_stick_y,
  input  logic signed [15:0]          right_stick_x,
  input  logic signed [15:0]          right_stick_y,
  output logic [23:0]                 down_mask,
  output logic [23:0]                 pressed_mask,
  output logic [15:0]                 left_trigger_level,
  output logic [15:0]                 right_trigger_level,
  output logic signed [15:0]          left_out_x,
  output logic signed [15:0]          left_out_y,
  output logic signed [15:0]          right_out_x,
  output logic signed [15:0]          right_out_y
);
  // dividend a*num*2^F*2 + den needs up to 17+24+F+1 bits, plus margin
  localparam int unsigned DW = 44 + STICK_FRAC_BITS;
  localparam int unsigned FullQ8 = 32767 * 256;

  logic [23:0]        prev_down;
  logic [7:0]         lt;
  logic [7:0]         rt;
  logic signed [16:0] lx;
  logic signed [16:0] lfy;
  logic signed [16:0] rx;
  logic signed [16:0] rfy;

  logic [DW-1:0] div_a;
  logic [DW-1:0] div_b;
  logic [DW-1:0] div_q;
  logic          div_start;

  logic [16:0] ax;
  logic [16:0] ay;
  logic        nx;
  logic        ny;
  logic [14:0] dz;
  logic [29:0] dz2;
  logic        zero;
  logic [47:0] sq_in;
  logic [23:0] mq;
  logic        sq_done;
  logic [24:0] num;
  logic [40:0] den;
  logic [41:0] pmul;
  logic [16:0] a_sel;

  // pressed bits and down mask
  function automatic logic [1:0] dir_bits(input logic signed [16:0] v,
                                          input logic [14:0] d);
    logic signed [16:0] sd;
    sd = signed'({2'b00, d});
    return {v > sd, v < -sd};
  endfunction

  logic [23:0] down_c;
  always_comb begin
    down_c = {dir_bits(17'(signed'(right_stick_x)), right_deadzone),
              dir_bits(-17'(signed'(right_stick_y)), right_deadzone),
              dir_bits(17'(signed'(left_stick_x)), left_deadzone),
              dir_bits(-17'(signed'(left_stick_y)), left_deadzone),
              right_trigger >= trigger_threshold,
              left_trigger >= trigger_threshold,
              buttons[15:12], buttons[9:0]};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      prev_down <= '0;
    end else if (cmd.load) begin
      prev_down <= down_c;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      down_mask <= down_c;
      pressed_mask <= down_c & ~prev_down;
      lt <= left_trigger;
      rt <= right_trigger;
      lx <= 17'(signed'(left_stick_x));
      lfy <= -17'(signed'(left_stick_y));
      rx <= 17'(signed'(right_stick_x));
      rfy <= -17'(signed'(right_stick_y));
    end
  end

  // trigger level through the shared divider
  logic [7:0] tv;
  logic       tlow;
  logic       tlow_r;
  logic [8:0] span;
  assign tv = cmd.trig_sel ? rt : lt;
  assign tlow = tv < trigger_threshold;
  assign span = 9'd255 - {1'b0, trigger_threshold};

  always_ff @(posedge clk) begin
    if (cmd.trig_start) begin
      tlow_r <= tlow;
    end
  end

  logic [15:0] tlevel;
  always_comb begin
    if (tlow_r) begin
      tlevel = '0;
    end else if (span == 9'd0 || div_q > DW'(65535)) begin
      tlevel = 16'hFFFF;
    end else begin
      tlevel = div_q[15:0];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.trig_store) begin
      if (cmd.trig_sel) begin
        right_trigger_level <= tlevel;
      end else begin
        left_trigger_level <= tlevel;
      end
    end
  end

  // stick magnitude and deadzone test
  always_ff @(posedge clk) begin
    if (cmd.stick_setup) begin
      ax <= cmd.stick_sel ? (rx[16] ? 17'(-rx) : 17'(rx)) : (lx[16] ? 17'(-lx) : 17'(lx));
      ay <= cmd.stick_sel ? (rfy[16] ? 17'(-rfy) : 17'(rfy))
                          : (lfy[16] ? 17'(-lfy) : 17'(lfy));
      nx <= cmd.stick_sel ? rx[16] : lx[16];
      ny <= cmd.stick_sel ? rfy[16] : lfy[16];
      dz <= cmd.stick_sel ? right_deadzone : left_deadzone;
    end
  end

  logic [33:0] sqx;
  logic [33:0] sqy;
  assign sqx = ax * ax;
  assign sqy = ay * ay;
  assign dz2 = dz * dz;

  // zero when within deadzone, deadzone saturated, or clamp below deadzone
  logic [33:0] m2_c;
  assign m2_c = sqx + sqy;
  always_comb begin
    zero = 1'b0;
    if (m2_c <= 34'(dz2) || dz == 15'h7FFF) begin
      zero = 1'b1;
    end
  end

  logic [23:0] mc;
  logic        num_zero;
  assign mc = (mq > 24'(FullQ8)) ? 24'(FullQ8) : mq;
  assign num_zero = mc <= {1'b0, dz, 8'd0};

  always_ff @(posedge clk) begin
    if (cmd.den_calc) begin
      num <= {1'b0, mc} - {2'b00, dz, 8'd0};
      den <= mq * (16'd32767 - {1'b0, dz});
    end
  end

  logic num_zero_r;
  always_ff @(posedge clk) begin
    if (rst) begin
      num_zero_r <= 1'b0;
    end else if (cmd.stick_setup) begin
      num_zero_r <= 1'b0;
    end else if (cmd.den_calc) begin
      num_zero_r <= num_zero;
    end
  end

  assign sq_in = {m2_c[31:0], 16'd0};
  assign status.stick_zero = zero | num_zero_r;

  gic_sqrt #(.W(48)) u_sqrt (
    .clk(clk), .rst(rst), .start(cmd.sqrt_start), .radicand(sq_in),
    .done(sq_done), .root(mq)
  );
  assign status.sqrt_done = sq_done;

  // product |f| * num, then dividend 2*p*2^F + den
  assign a_sel = cmd.num_y ? ay : ax;
  always_ff @(posedge clk) begin
    if (cmd.num_x || cmd.num_y) begin
      pmul <= a_sel * num;
    end
  end

  logic num_pend;
  always_ff @(posedge clk) begin
    if (rst) begin
      num_pend <= 1'b0;
    end else begin
      num_pend <= cmd.num_x | cmd.num_y;
    end
  end

  logic trig_pend;
  always_ff @(posedge clk) begin
    if (rst) begin
      trig_pend <= 1'b0;
    end else begin
      trig_pend <= cmd.trig_start;
    end
  end

  always_comb begin
    if (trig_pend) begin
      div_a = DW'({(tv - trigger_threshold), 16'd0});
      div_b = DW'(span);
    end else begin
      div_a = (DW'(pmul) << (STICK_FRAC_BITS + 1)) + DW'(den);
      div_b = DW'(den) << 1;
    end
  end
  assign div_start = trig_pend | num_pend;

  gic_div #(.W(DW)) u_div (
    .clk(clk), .rst(rst), .start(div_start), .dividend(div_a), .divisor(div_b),
    .done(status.div_done), .quotient(div_q)
  );

  logic [15:0] axv;
  logic        sat;
  assign sat = div_q > DW'(32767);
  assign axv = sat ? 16'd32767 : div_q[15:0];

  logic signed [15:0] xr;
  logic signed [15:0] yv;
  assign yv = status.stick_zero ? 16'sd0 : (ny ? -signed'(axv) : signed'(axv));

  always_ff @(posedge clk) begin
    if (cmd.store_x) begin
      xr <= status.stick_zero ? 16'sd0 : (nx ? -signed'(axv) : signed'(axv));
    end
  end

  // both stores together only on the zero path
  always_ff @(posedge clk) begin
    if (cmd.store_y) begin
      if (cmd.stick_sel) begin
        right_out_x <= cmd.store_x ? 16'sd0 : xr;
        right_out_y <= yv;
      end else begin
        left_out_x <= cmd.store_x ? 16'sd0 : xr;
        left_out_y <= yv;
      end
    end
  end
endmodule

FILE: bench/tb_gic_if.sv
// testbench copy note: channel interfaces come from hdl/gic_if.sv
// this file holds testbench-side helper types for the conditioner bench
// no dependencies
`timescale 1ns / 100ps
package tb_gic_pkg;
  typedef struct packed {
    logic [15:0]        buttons;
    logic [7:0]         left_trigger;
    logic [7:0]         right_trigger;
    logic signed [15:0] lx;
    logic signed [15:0] ly;
    logic signed [15:0] rx;
    logic signed [15:0] ry;
  } poll_t;

  typedef struct packed {
    logic [23:0]        down_mask;
    logic [23:0]        pressed_mask;
    logic [15:0]        lt_level;
    logic [15:0]        rt_level;
    logic signed [15:0] lox;
    logic signed [15:0] loy;
    logic signed [15:0] rox;
    logic signed [15:0] roy;
  } cond_t;
endpackage

FILE: bench/tb.sv
// testbench for gamepad_input_conditioner_top: directed and random polls with config phases
// a built-in predictor computes masks, trigger levels and stick vectors for each transaction
// depends on gic_pkg, gic_if, tb_gic_pkg and the conditioner rtl
`timescale 1ns / 100ps
module tb;

  localparam int FRAC = 15;
  localparam int LIMIT = 10000000;

  logic clk = 1'b0;
  logic rst = 1'b1;

  gic_in_if  in_ch ();
  gic_out_if out_ch ();
  gic_cfg_if cfg_ch ();

  gamepad_input_conditioner_top #(.STICK_FRAC_BITS(FRAC)) DUT (
    .clk(clk), .rst(rst), .in(in_ch), .out(out_ch), .cfg(cfg_ch)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  tb_gic_pkg::poll_t polls_q[$];
  tb_gic_pkg::cond_t cond_q[$];
  int    errors = 0;
  int    cycles = 0;
  int    in_gap = 0;
  int    out_gap = 0;

  logic [7:0]  thr_m;
  logic [14:0] ldz_m, rdz_m;
  logic [23:0] prev_m;

  function automatic int gap_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 40) return 0;
    if (r < 90) return $urandom_range(1, 4);
    return $urandom_range(20, 300);
  endfunction

  function automatic logic [63:0] isqrt(logic [63:0] n);
    logic [63:0] res, bitv;
    res = 0;
    bitv = 64'd1 << 62;
    while (bitv > n) bitv >>= 2;
    while (bitv != 0) begin
      if (n >= res + bitv) begin
        n -= res + bitv;
        res = (res >> 1) + bitv;
      end else begin
        res >>= 1;
      end
      bitv >>= 2;
    end
    return res;
  endfunction

  function automatic logic [15:0] trig_level(logic [7:0] v, logic [7:0] thr);
    logic [31:0] q;
    if (v < thr) return 16'd0;
    if (thr == 8'd255) return 16'hFFFF;
    q = ({24'd0, v - thr} << 16) / (32'd255 - {24'd0, thr});
    return q > 32'd65535 ? 16'hFFFF : q[15:0];
  endfunction

  function automatic logic signed [15:0] axis_scale(longint f, logic [127:0] num,
                                                    logic [127:0] den);
    logic [127:0] a, p, q;
    a = 128'(f < 0 ? -f : f);
    p = (a * num) << FRAC;
    q = (2 * p + den) / (2 * den);
    if (q > 32767) q = 32767;
    return f < 0 ? -q[15:0] : q[15:0];
  endfunction

  function automatic void stick_vec(longint x, longint y, logic [14:0] dz,
                                    output logic signed [15:0] ox,
                                    output logic signed [15:0] oy);
    longint fy, d;
    logic [63:0] m2, mq, mc;
    fy = -y;
    d = longint'(dz);
    ox = 0;
    oy = 0;
    m2 = x * x + fy * fy;
    if (m2 <= d * d || d >= 32767) return;
    mq = isqrt(m2 << 16);
    mc = mq > 32767 * 256 ? 32767 * 256 : mq;
    if (mc <= d * 256) return;
    ox = axis_scale(x, 128'(mc - d * 256), 128'(mq * (32767 - d)));
    oy = axis_scale(fy, 128'(mc - d * 256), 128'(mq * (32767 - d)));
  endfunction

  function automatic logic [1:0] dir_pair(longint v, logic [14:0] dz);
    longint d;
    d = longint'(dz);
    return {v > d, v < -d};
  endfunction

  function automatic tb_gic_pkg::cond_t condition_poll(tb_gic_pkg::poll_t p);
    tb_gic_pkg::cond_t c;
    logic [23:0] dn;
    dn = {dir_pair(p.rx, rdz_m), dir_pair(-longint'(p.ry), rdz_m),
          dir_pair(p.lx, ldz_m), dir_pair(-longint'(p.ly), ldz_m),
          p.right_trigger >= thr_m, p.left_trigger >= thr_m,
          p.buttons[15:12], p.buttons[9:0]};
    c.down_mask = dn;
    c.pressed_mask = dn & ~prev_m;
    prev_m = dn;
    c.lt_level = trig_level(p.left_trigger, thr_m);
    c.rt_level = trig_level(p.right_trigger, thr_m);
    stick_vec(p.lx, p.ly, ldz_m, c.lox, c.loy);
    stick_vec(p.rx, p.ry, rdz_m, c.rox, c.roy);
    return c;
  endfunction

  task automatic report(string what, logic [31:0] got, logic [31:0] want);
    $display("mismatch %s: got %0h expected %0h", what, got, want);
    errors++;
  endtask

  // driver
  always @(posedge clk) begin
    if (rst) begin
      in_ch.valid <= 1'b0;
      in_gap <= 0;
    end else if (in_ch.valid && !in_ch.ready) begin
    end else if (in_gap > 0) begin
      in_gap <= in_gap - 1;
      in_ch.valid <= 1'b0;
    end else if (polls_q.size() > 0) begin
      tb_gic_pkg::poll_t p;
      p = polls_q.pop_front();
      cond_q.push_back(condition_poll(p));
      in_ch.valid <= 1'b1;
      in_ch.buttons <= p.buttons;
      in_ch.left_trigger <= p.left_trigger;
      in_ch.right_trigger <= p.right_trigger;
      in_ch.left_stick_x <= p.lx;
      in_ch.left_stick_y <= p.ly;
      in_ch.right_stick_x <= p.rx;
      in_ch.right_stick_y <= p.ry;
      in_gap <= gap_len();
    end else begin
      in_ch.valid <= 1'b0;
    end
  end

  // monitor
  always @(posedge clk) begin
    cycles++;
    if (rst) begin
      out_ch.ready <= 1'b0;
    end else begin
      if (out_ch.valid && out_ch.ready) begin
        if (cond_q.size() == 0) begin
          report("unexpected", 32'd0, 32'd0);
        end else begin
          tb_gic_pkg::cond_t e;
          e = cond_q.pop_front();
          if (out_ch.down_mask !== e.down_mask)
            report("down", 32'(out_ch.down_mask), 32'(e.down_mask));
          if (out_ch.pressed_mask !== e.pressed_mask)
            report("pressed", 32'(out_ch.pressed_mask), 32'(e.pressed_mask));
          if (out_ch.left_trigger_level !== e.lt_level)
            report("lt", 32'(out_ch.left_trigger_level), 32'(e.lt_level));
          if (out_ch.right_trigger_level !== e.rt_level)
            report("rt", 32'(out_ch.right_trigger_level), 32'(e.rt_level));
          if (out_ch.left_out_x !== e.lox)
            report("lox", 32'(out_ch.left_out_x), 32'(e.lox));
          if (out_ch.left_out_y !== e.loy)
            report("loy", 32'(out_ch.left_out_y), 32'(e.loy));
          if (out_ch.right_out_x !== e.rox)
            report("rox", 32'(out_ch.right_out_x), 32'(e.rox));
          if (out_ch.right_out_y !== e.roy)
            report("roy", 32'(out_ch.right_out_y), 32'(e.roy));
        end
      end
      if (out_gap > 0) begin
        out_gap <= out_gap - 1;
        out_ch.ready <= 1'b0;
      end else begin
        out_ch.ready <= 1'b1;
        if ($urandom_range(0, 3) == 0) out_gap <= gap_len();
      end
    end
    if (cycles > LIMIT) begin
      $display("FAIL");
      $finish;
    end
  end

  function automatic logic signed [15:0] axis_val();
    int r;
    r = $urandom_range(0, 9);
    if (r == 0) return 16'sh8000;
    if (r == 1) return 16'sd32767;
    if (r < 4) return 16'($urandom_range(0, 20000) - 10000);
    return 16'($urandom());
  endfunction

  function automatic tb_gic_pkg::poll_t rand_poll();
    tb_gic_pkg::poll_t p;
    p.buttons = ($urandom_range(0, 3) == 0) ? 16'($urandom()) : 16'($urandom()) & 16'hF3FF;
    p.left_trigger = $urandom_range(0, 4) == 0 ? 8'd255 : 8'($urandom());
    p.right_trigger = 8'($urandom());
    p.lx = axis_val();
    p.ly = axis_val();
    p.rx = axis_val();
    p.ry = axis_val();
    return p;
  endfunction

  task automatic add_poll(logic [15:0] b, logic [7:0] lt, logic [7:0] rt,
                          logic [15:0] lx, logic [15:0] ly, logic [15:0] rx,
                          logic [15:0] ry);
    polls_q.push_back('{b, lt, rt, lx, ly, rx, ry});
  endtask

  task automatic cfg_write(gic_pkg::reg_idx_t idx, logic [15:0] val);
    @(posedge clk);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= idx;
    cfg_ch.data <= val;
    do @(posedge clk); while (!cfg_ch.ready);
    cfg_ch.valid <= 1'b0;
    case (idx)
      gic_pkg::REG_TRIGGER_THRESHOLD: thr_m = val[7:0];
      gic_pkg::REG_LEFT_DEADZONE:     ldz_m = val[14:0];
      gic_pkg::REG_RIGHT_DEADZONE:    rdz_m = val[14:0];
      default: ;
    endcase
  endtask

  task automatic drain();
    while (polls_q.size() > 0 || cond_q.size() > 0 || in_ch.valid) @(posedge clk);
    repeat (400) @(posedge clk);
  endtask

  initial begin
    in_ch.valid = 1'b0;
    in_ch.buttons = 0;
    in_ch.left_trigger = 0;
    in_ch.right_trigger = 0;
    in_ch.left_stick_x = 0;
    in_ch.left_stick_y = 0;
    in_ch.right_stick_x = 0;
    in_ch.right_stick_y = 0;
    out_ch.ready = 1'b0;
    cfg_ch.valid = 1'b0;
    cfg_ch.index = gic_pkg::REG_TRIGGER_THRESHOLD;
    cfg_ch.data = 0;
    thr_m = 8'd30;
    ldz_m = 15'd7849;
    rdz_m = 15'd8689;
    prev_m = 0;
    repeat (3) @(posedge clk);
    rst <= 1'b0;

    // directed: extremes, y wrap, unused bits, inside and outside deadzone
    add_poll(16'h0000, 8'd0, 8'd0, 16'h0000, 16'h0000, 16'h0000, 16'h0000);
    add_poll(16'hFFFF, 8'd255, 8'd255, 16'h7FFF, 16'h8000, 16'h8000, 16'h7FFF);
    add_poll(16'hFFFF, 8'd30, 8'd29, 16'h8000, 16'h8000, 16'h7FFF, 16'h7FFF);
    add_poll(16'h0C00, 8'd31, 8'd254, 16'd7849, 16'd0, 16'd8690, 16'd0);
    add_poll(16'h0C00, 8'd0, 8'd0, 16'd7850, -16'sd7850, -16'sd8690, 16'd8690);
    add_poll(16'hF3FF, 8'd128, 8'd200, 16'd6000, 16'd6000, 16'd100, -16'sd100);
    drain();
    cfg_write(gic_pkg::REG_TRIGGER_THRESHOLD, 16'd255);
    cfg_write(gic_pkg::REG_LEFT_DEADZONE, 16'd32767);
    cfg_write(gic_pkg::REG_RIGHT_DEADZONE, 16'd0);
    cfg_write(gic_pkg::REG_UNUSED, 16'hFFFF);
    add_poll(16'h1234, 8'd254, 8'd255, 16'h7FFF, 16'h8000, 16'd1, 16'd0);
    add_poll(16'h4321, 8'd255, 8'd0, 16'h8000, 16'h7FFF, 16'd0, -16'sd1);
    add_poll(16'h0000, 8'd0, 8'd255, 16'd0, 16'd0, 16'h8000, 16'h8000);
    drain();
    cfg_write(gic_pkg::REG_TRIGGER_THRESHOLD, 16'd0);
    cfg_write(gic_pkg::REG_LEFT_DEADZONE, 16'd32766);
    cfg_write(gic_pkg::REG_RIGHT_DEADZONE, 16'hFFFF);
    add_poll(16'h8001, 8'd0, 8'd255, 16'h7FFF, 16'h7FFF, 16'h8000, 16'h8000);
    add_poll(16'h0000, 8'd1, 8'd0, 16'h8000, 16'h8000, 16'h7FFF, 16'h0000);
    drain();

    for (int ph = 0; ph < 6; ph++) begin
      cfg_write(gic_pkg::REG_TRIGGER_THRESHOLD, 16'($urandom_range(0, 255)));
      cfg_write(gic_pkg::REG_LEFT_DEADZONE,
                ph == 0 ? 16'd0 : 16'($urandom_range(0, 20000)));
      cfg_write(gic_pkg::REG_RIGHT_DEADZONE,
                ph == 5 ? 16'd32766 : 16'($urandom_range(0, 20000)));
      for (int i = 0; i < 275; i++) polls_q.push_back(rand_poll());
      drain();
    end
    if (errors == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end
endmodule

FILE: sim.f
hdl/gic_pkg.sv
hdl/gic_if.sv
hdl/gic_div.sv
hdl/gic_sqrt.sv
hdl/gic_ctrl.sv
hdl/gic_dp.sv
hdl/gamepad_input_conditioner_top.sv
bench/tb_gic_if.sv
bench/tb.sv
